>>> src/obbt_pkg.sv
// obbt_pkg: widths, item and handshake types shared by the box overlap test modules.
// No dependencies.
`default_nettype none

package obbt_pkg;

  localparam int CW       = 20;              // coordinate component width
  localparam int AW       = 16;              // axis component width
  localparam int AXIS_FRAC = AW - 2;         // 1.0 on an axis = 2^AXIS_FRAC
  localparam int LEN_W    = CW + 2;          // doubled lengths, sums of three corners
  localparam int TA_W     = LEN_W + AW + 2;  // T projected on an axis
  localparam int R_W      = 2 * AW + 2;      // axis cosine, sum of three products
  localparam int HR_W     = LEN_W + R_W;     // half length times cosine
  localparam int SPLIT_W  = TA_W / 2;        // low part of T projection in the split product
  localparam int TRL_W    = SPLIT_W + 1 + R_W;
  localparam int TRH_W    = (TA_W - SPLIT_W) + R_W;
  localparam int TR_W     = TA_W + R_W;
  localparam int DW       = TR_W + 2;        // comparison width, signed
  localparam int ABS_SUM_W = HR_W + 2;       // sum of up to four absolute products
  localparam int CD_W     = TR_W + 1;        // cross-axis distance before abs
  localparam int N_AXES   = 15;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = OUTQ_AW + 1;
  localparam int FILL_W     = OUTQ_CW + 1;   // in flight plus queued

  localparam logic CMD_OBB  = 1'b0;
  localparam logic CMD_AABB = 1'b1;

  typedef logic signed [LEN_W-1:0] len_t;
  typedef logic signed [AW-1:0]    axis_t;

  // Decoded item handed from front to back.
  typedef struct packed {
    len_t  [2:0]      t;   // center difference, doubled
    len_t  [2:0]      ha;  // A half lengths, doubled
    len_t  [2:0]      hb;  // B half lengths, doubled
    axis_t [2:0][2:0] ax;  // [axis][component]
    axis_t [2:0][2:0] bx;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic valid;
    logic overlap;
  } res_t;

endpackage

`default_nettype wire

>>> src/oriented_box_overlap_test_unit.sv
// Oriented box overlap test, 15-axis separating axis test, exact fixed point.
// An item is held in the front queue, then passes back stages A to D into the result queue.
// Throughput: one item per cycle, set by the fully pipelined back end; the 8-entry result
// queue and credit count keep that rate while the result side pops every cycle.
// Reset (rst, synchronous, active high) empties both queues and the pipeline; no other state.
// Depends on obbt_pkg, obbt_front, obbt_back, obbt_outq.
`default_nettype none

module oriented_box_overlap_test_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         command,
  input  wire logic [3*obbt_pkg::CW-1:0]    a_center,
  input  wire logic [3*obbt_pkg::AW-1:0]    a_axis_x,
  input  wire logic [3*obbt_pkg::AW-1:0]    a_axis_y,
  input  wire logic [3*obbt_pkg::AW-1:0]    a_axis_z,
  input  wire logic [3*obbt_pkg::CW-1:0]    a_half,
  input  wire logic [3*obbt_pkg::AW-1:0]    b_axis_x,
  input  wire logic [3*obbt_pkg::AW-1:0]    b_axis_y,
  input  wire logic [3*obbt_pkg::AW-1:0]    b_axis_z,
  input  wire logic [3*obbt_pkg::CW-1:0]    b_first,
  input  wire logic [3*obbt_pkg::CW-1:0]    b_second,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              overlap
);

  // Front decodes each item (axis-aligned B becomes identity axes with
  // doubled center and half lengths) into a two-entry queue.
  obbt_pkg::head_t             head;
  logic                        take;
  // Back issues from that queue only when the result queue has room for
  // everything already in flight, so its pipeline never stalls.
  obbt_pkg::res_t              res;
  logic [obbt_pkg::OUTQ_CW-1:0] outq_cnt;

  obbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .command  (command),
    .a_center (a_center),
    .a_axis_x (a_axis_x),
    .a_axis_y (a_axis_y),
    .a_axis_z (a_axis_z),
    .a_half   (a_half),
    .b_axis_x (b_axis_x),
    .b_axis_y (b_axis_y),
    .b_axis_z (b_axis_z),
    .b_first  (b_first),
    .b_second (b_second),
    .head     (head),
    .take     (take)
  );

  obbt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .take     (take),
    .outq_cnt (outq_cnt),
    .res      (res)
  );

  obbt_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .res     (res),
    .pop     (pop),
    .empty   (empty),
    .overlap (overlap),
    .cnt     (outq_cnt)
  );

endmodule

`default_nettype wire

>>> src/obbt_front.sv
// obbt_front: accepts box pairs, decodes command into doubled lengths and axes,
// and holds them in a two-entry queue for the back end. Depends on obbt_pkg.
`default_nettype none

module obbt_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic                   command,
  input  wire logic [3*obbt_pkg::CW-1:0] a_center,
  input  wire logic [3*obbt_pkg::AW-1:0] a_axis_x,
  input  wire logic [3*obbt_pkg::AW-1:0] a_axis_y,
  input  wire logic [3*obbt_pkg::AW-1:0] a_axis_z,
  input  wire logic [3*obbt_pkg::CW-1:0] a_half,
  input  wire logic [3*obbt_pkg::AW-1:0] b_axis_x,
  input  wire logic [3*obbt_pkg::AW-1:0] b_axis_y,
  input  wire logic [3*obbt_pkg::AW-1:0] b_axis_z,
  input  wire logic [3*obbt_pkg::CW-1:0] b_first,
  input  wire logic [3*obbt_pkg::CW-1:0] b_second,
  output obbt_pkg::head_t             head,
  input  wire logic                   take
);

  obbt_pkg::item_t dec;
  obbt_pkg::item_t mem [2];
  logic            wp, rp;
  logic [1:0]      cnt;
  logic            wr, rd;

  always_comb begin
    obbt_pkg::len_t ac, p, q, h;
    dec = '0;
    for (int c = 0; c < 3; c++) begin
      ac = $signed(a_center[c*obbt_pkg::CW +: obbt_pkg::CW]);
      p  = $signed(b_first[c*obbt_pkg::CW +: obbt_pkg::CW]);
      q  = $signed(b_second[c*obbt_pkg::CW +: obbt_pkg::CW]);
      h  = $signed(a_half[c*obbt_pkg::CW +: obbt_pkg::CW]);
      dec.ha[c]    = h <<< 1;
      dec.ax[0][c] = $signed(a_axis_x[c*obbt_pkg::AW +: obbt_pkg::AW]);
      dec.ax[1][c] = $signed(a_axis_y[c*obbt_pkg::AW +: obbt_pkg::AW]);
      dec.ax[2][c] = $signed(a_axis_z[c*obbt_pkg::AW +: obbt_pkg::AW]);
      if (command == obbt_pkg::CMD_AABB) begin
        dec.t[c]  = p + q - (ac <<< 1);
        dec.hb[c] = q - p;
        for (int i = 0; i < 3; i++) begin
          dec.bx[i][c] = (i == c) ? obbt_pkg::axis_t'(1 << obbt_pkg::AXIS_FRAC) : '0;
        end
      end else begin
        dec.t[c]     = (p - ac) <<< 1;
        dec.hb[c]    = q <<< 1;
        dec.bx[0][c] = $signed(b_axis_x[c*obbt_pkg::AW +: obbt_pkg::AW]);
        dec.bx[1][c] = $signed(b_axis_y[c*obbt_pkg::AW +: obbt_pkg::AW]);
        dec.bx[2][c] = $signed(b_axis_z[c*obbt_pkg::AW +: obbt_pkg::AW]);
      end
    end
  end

  assign full       = (cnt == 2'd2);
  assign wr         = push && !full;
  assign rd         = take && (cnt != 2'd0);
  assign head.valid = (cnt != 2'd0);
  assign head.item  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("front queue count out of range");
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    take |-> head.valid)
    else $error("back end took from empty front queue");

endmodule

`default_nettype wire

>>> src/obbt_back.sv
// obbt_back: four-stage pipeline of projections, products and sums for the
// fifteen separating axes, plus the final compare. Depends on obbt_pkg.
`default_nettype none

module obbt_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire obbt_pkg::head_t           head,
  output logic                           take,
  input  wire logic [obbt_pkg::OUTQ_CW-1:0] outq_cnt,
  output obbt_pkg::res_t                 res
);

  logic va, vb, vc, vd;
  logic [obbt_pkg::FILL_W-1:0] fill;

  // stage A
  logic signed [obbt_pkg::TA_W-1:0] ta_a [3], tb_a [3];
  logic signed [obbt_pkg::R_W-1:0]  r_a [3][3];
  obbt_pkg::len_t                   ha_a [3], hb_a [3];
  logic signed [obbt_pkg::TA_W-1:0] ta_n [3], tb_n [3];
  logic signed [obbt_pkg::R_W-1:0]  r_n [3][3];

  // stage B
  logic signed [obbt_pkg::HR_W-1:0]  hr_b [3][3][3], br_b [3][3][3];
  logic signed [obbt_pkg::TRL_W-1:0] trl_b [3][3][3];
  logic signed [obbt_pkg::TRH_W-1:0] trh_b [3][3][3];
  logic signed [obbt_pkg::TA_W-1:0]  ta_b [3], tb_b [3];
  obbt_pkg::len_t                    ha_b [3], hb_b [3];

  // stage C
  logic [obbt_pkg::HR_W-1:0]        hra_c [3][3][3], bra_c [3][3][3];
  logic signed [obbt_pkg::TR_W-1:0] tr_c [3][3][3];
  logic [obbt_pkg::TA_W-1:0]        taa_c [3], tba_c [3];
  obbt_pkg::len_t                   ha_c [3], hb_c [3];

  // stage D
  logic signed [obbt_pkg::DW-1:0] dist_d [obbt_pkg::N_AXES];
  logic signed [obbt_pkg::DW-1:0] rad_d  [obbt_pkg::N_AXES];
  logic signed [obbt_pkg::DW-1:0] dist_n [obbt_pkg::N_AXES];
  logic signed [obbt_pkg::DW-1:0] rad_n  [obbt_pkg::N_AXES];

  logic sep;

  // Credit: items in flight plus queued results never exceed the result queue.
  assign fill = obbt_pkg::FILL_W'(va) + obbt_pkg::FILL_W'(vb) + obbt_pkg::FILL_W'(vc)
              + obbt_pkg::FILL_W'(vd) + obbt_pkg::FILL_W'(outq_cnt);
  assign take = head.valid && (fill < obbt_pkg::FILL_W'(obbt_pkg::OUTQ_DEPTH));

  always_comb begin
    logic signed [obbt_pkg::TA_W-1:0] sa, sb;
    logic signed [obbt_pkg::R_W-1:0]  sr;
    for (int i = 0; i < 3; i++) begin
      sa = '0;
      sb = '0;
      for (int c = 0; c < 3; c++) begin
        sa = sa + $signed(head.item.t[c]) * $signed(head.item.ax[i][c]);
        sb = sb + $signed(head.item.t[c]) * $signed(head.item.bx[i][c]);
      end
      ta_n[i] = sa;
      tb_n[i] = sb;
      for (int j = 0; j < 3; j++) begin
        sr = '0;
        for (int c = 0; c < 3; c++) begin
          sr = sr + $signed(head.item.ax[i][c]) * $signed(head.item.bx[j][c]);
        end
        r_n[i][j] = sr;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ta_a[i] <= ta_n[i];
      tb_a[i] <= tb_n[i];
      ha_a[i] <= head.item.ha[i];
      hb_a[i] <= head.item.hb[i];
      for (int j = 0; j < 3; j++) r_a[i][j] <= r_n[i][j];
    end
  end

  // Products; T projection times cosine is split in two halves.
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      ta_b[a] <= ta_a[a];
      tb_b[a] <= tb_a[a];
      ha_b[a] <= ha_a[a];
      hb_b[a] <= hb_a[a];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          hr_b[a][k][j]  <= ha_a[a] * r_a[k][j];
          br_b[a][k][j]  <= hb_a[a] * r_a[k][j];
          trl_b[a][k][j] <= $signed({1'b0, ta_a[a][obbt_pkg::SPLIT_W-1:0]}) * r_a[k][j];
          trh_b[a][k][j] <= $signed(ta_a[a][obbt_pkg::TA_W-1:obbt_pkg::SPLIT_W])
                            * r_a[k][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      taa_c[a] <= ta_b[a][obbt_pkg::TA_W-1] ? obbt_pkg::TA_W'(-ta_b[a])
                                             : obbt_pkg::TA_W'(ta_b[a]);
      tba_c[a] <= tb_b[a][obbt_pkg::TA_W-1] ? obbt_pkg::TA_W'(-tb_b[a])
                                             : obbt_pkg::TA_W'(tb_b[a]);
      ha_c[a]  <= ha_b[a];
      hb_c[a]  <= hb_b[a];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          hra_c[a][k][j] <= hr_b[a][k][j][obbt_pkg::HR_W-1]
                            ? obbt_pkg::HR_W'(-hr_b[a][k][j]) : obbt_pkg::HR_W'(hr_b[a][k][j]);
          bra_c[a][k][j] <= br_b[a][k][j][obbt_pkg::HR_W-1]
                            ? obbt_pkg::HR_W'(-br_b[a][k][j]) : obbt_pkg::HR_W'(br_b[a][k][j]);
          tr_c[a][k][j]  <= $signed({trh_b[a][k][j], {obbt_pkg::SPLIT_W{1'b0}}})
                            + trl_b[a][k][j];
        end
      end
    end
  end

  // Distances and radii: A axes 0..2, B axes 3..5, cross axes 6 + 3i + j.
  always_comb begin
    logic [obbt_pkg::ABS_SUM_W-1:0]   s;
    logic signed [obbt_pkg::CD_W-1:0] d;
    logic [obbt_pkg::CD_W-1:0]        da;
    int i1, i2, j1, j2;
    for (int i = 0; i < 3; i++) begin
      dist_n[i] = $signed({{(obbt_pkg::DW-obbt_pkg::TA_W-obbt_pkg::AXIS_FRAC){1'b0}},
                           taa_c[i], {obbt_pkg::AXIS_FRAC{1'b0}}});
      s = obbt_pkg::ABS_SUM_W'(bra_c[0][i][0]) + obbt_pkg::ABS_SUM_W'(bra_c[1][i][1])
        + obbt_pkg::ABS_SUM_W'(bra_c[2][i][2]);
      rad_n[i] = $signed({ha_c[i], {(2*obbt_pkg::AXIS_FRAC){1'b0}}})
               + $signed({{(obbt_pkg::DW-obbt_pkg::ABS_SUM_W){1'b0}}, s});
      dist_n[3+i] = $signed({{(obbt_pkg::DW-obbt_pkg::TA_W-obbt_pkg::AXIS_FRAC){1'b0}},
                             tba_c[i], {obbt_pkg::AXIS_FRAC{1'b0}}});
      s = obbt_pkg::ABS_SUM_W'(hra_c[0][0][i]) + obbt_pkg::ABS_SUM_W'(hra_c[1][1][i])
        + obbt_pkg::ABS_SUM_W'(hra_c[2][2][i]);
      rad_n[3+i] = $signed({hb_c[i], {(2*obbt_pkg::AXIS_FRAC){1'b0}}})
                 + $signed({{(obbt_pkg::DW-obbt_pkg::ABS_SUM_W){1'b0}}, s});
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        d  = tr_c[i2][i1][j] - tr_c[i1][i2][j];
        da = d[obbt_pkg::CD_W-1] ? obbt_pkg::CD_W'(-d) : obbt_pkg::CD_W'(d);
        dist_n[6+3*i+j] = $signed({{(obbt_pkg::DW-obbt_pkg::CD_W){1'b0}}, da});
        s = obbt_pkg::ABS_SUM_W'(hra_c[i1][i2][j]) + obbt_pkg::ABS_SUM_W'(hra_c[i2][i1][j])
          + obbt_pkg::ABS_SUM_W'(bra_c[j1][i][j2]) + obbt_pkg::ABS_SUM_W'(bra_c[j2][i][j1]);
        rad_n[6+3*i+j] = $signed({{(obbt_pkg::DW-obbt_pkg::ABS_SUM_W-obbt_pkg::AXIS_FRAC){1'b0}},
                                  s, {obbt_pkg::AXIS_FRAC{1'b0}}});
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < obbt_pkg::N_AXES; n++) begin
      dist_d[n] <= dist_n[n];
      rad_d[n]  <= rad_n[n];
    end
  end

  always_comb begin
    sep = 1'b0;
    for (int n = 0; n < obbt_pkg::N_AXES; n++) begin
      if (dist_d[n] > rad_d[n]) sep = 1'b1;
    end
  end

  assign res.valid   = vd;
  assign res.overlap = !sep;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= take;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    fill <= obbt_pkg::FILL_W'(obbt_pkg::OUTQ_DEPTH))
    else $error("results in flight exceed result queue space");
  a_pipe: assert property (@(posedge clk) disable iff (rst) take |=> va)
    else $error("issued item lost from pipeline");

endmodule

`default_nettype wire

>>> src/obbt_outq.sv
// obbt_outq: result queue of overlap bits, read from the head.
// Depends on obbt_pkg.
`default_nettype none

module obbt_outq (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire obbt_pkg::res_t          res,
  input  wire logic                    pop,
  output logic                         empty,
  output logic                         overlap,
  output logic [obbt_pkg::OUTQ_CW-1:0] cnt
);

  logic [obbt_pkg::OUTQ_DEPTH-1:0] mem;
  logic [obbt_pkg::OUTQ_AW-1:0]    wp, rp;
  logic                            rd;

  assign empty   = (cnt == '0);
  assign rd      = pop && !empty;
  assign overlap = mem[rp];

  always_ff @(posedge clk) begin
    if (res.valid) mem[wp] <= res.overlap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (res.valid) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + obbt_pkg::OUTQ_CW'(res.valid) - obbt_pkg::OUTQ_CW'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (cnt < obbt_pkg::OUTQ_CW'(obbt_pkg::OUTQ_DEPTH)) || rd)
    else $error("result written into full queue");

endmodule

`default_nettype wire
